FILE: design/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

    // result kinds, carried on m_tuser
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_BAD_END = 3'd3;
    localparam logic [2:0] KIND_BAD_OP  = 3'd4;
    localparam logic [2:0] KIND_STRAY   = 3'd5;

    // parser phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_OP    = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;

    // operation codes
    localparam logic [2:0] OP_UPPER = 3'd0;
    localparam logic [2:0] OP_LOWER = 3'd1;
    localparam logic [2:0] OP_UPPER_ALT = 3'd5;
    localparam logic [7:0] OP_MAX = 8'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [1:0] CFG_END_BYTE     = 2'd1;
    localparam logic [1:0] CFG_SMALL_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_MEDIUM_LIMIT = 2'd3;

    localparam logic [7:0] RST_START_BYTE   = 8'h55;
    localparam logic [7:0] RST_END_BYTE     = 8'hAA;
    localparam logic [8:0] RST_SMALL_LIMIT  = 9'd64;
    localparam logic [8:0] RST_MEDIUM_LIMIT = 9'd128;

    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [1:0] SIZE_SMALL  = 2'd0;
    localparam logic [1:0] SIZE_MEDIUM = 2'd1;
    localparam logic [1:0] SIZE_LARGE  = 2'd2;

    typedef struct packed {
        logic       dispatched;
        logic [1:0] size_class;
        logic [7:0] position;
        logic [7:0] value;
        logic [2:0] operation;
    } result_t;

endpackage

`default_nettype wire

FILE: design/framed_packet_receive_parser.sv
// Framed packet receive parser.
// Input stream s_*: one received byte per beat in s_tdata[7:0].
// Output stream m_*: at most one result per input beat; kind on m_tuser,
// the other result fields in m_tdata, final payload byte flagged on m_tlast.
// Frames are start byte, operation, length, payload bytes, end byte; the
// header result comes out on the length byte, payload bytes cut through.
// Each result is registered and appears on m_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle, set by the single output register; the
// next byte is taken in the same cycle that the waiting result is taken.
// When the receiver stalls, s_tready drops until the output register is
// emptied; bytes that give no result are held back the same way.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 start
// byte, 1 end byte, 2 small limit, 3 medium limit); write only when idle.
// Reset: registers return to 0x55, 0xAA, 64, 128, the parser waits for a
// start byte and the output register is emptied.
`default_nettype none

module framed_packet_receive_parser
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,   // rx_byte
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [23:0]       m_tdata,   // operation, value, position, size_class,
                                         // dispatched, zero pad
    output logic [2:0]        m_tuser,   // kind
    output logic              m_tlast,   // payload_last
    input  wire  logic        cfg_we,
    input  wire  logic [1:0]  cfg_addr,
    input  wire  logic [8:0]  cfg_wdata
);
    import fpr_pkg::*;

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic [8:0] small_reg;
    logic [8:0] medium_reg;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] op_reg, op_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] seen_reg, seen_next;

    logic       out_valid_reg;
    result_t    res_reg, res_next;
    logic [2:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       emit;
    logic       accept;
    logic       is_last;
    logic [7:0] conv;

    function automatic logic [1:0] size_of(input logic [7:0] len,
                                           input logic [8:0] lim_s,
                                           input logic [8:0] lim_m);
        logic [8:0] l;
        l = {1'b0, len};
        if (l < lim_s)
            size_of = SIZE_SMALL;
        else if (l < lim_m)
            size_of = SIZE_MEDIUM;
        else
            size_of = SIZE_LARGE;
    endfunction

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= RST_START_BYTE;
            end_reg    <= RST_END_BYTE;
            small_reg  <= RST_SMALL_LIMIT;
            medium_reg <= RST_MEDIUM_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_START_BYTE:   start_reg  <= cfg_wdata[7:0];
                CFG_END_BYTE:     end_reg    <= cfg_wdata[7:0];
                CFG_SMALL_LIMIT:  small_reg  <= cfg_wdata;
                CFG_MEDIUM_LIMIT: medium_reg <= cfg_wdata;
                default:          start_reg  <= start_reg;
            endcase
        end
    end

    // case conversion of a payload byte
    always_comb
    begin
        conv = s_tdata;
        if ((op_reg == OP_UPPER || op_reg == OP_UPPER_ALT)
            && s_tdata >= CHR_LOWER_A && s_tdata <= CHR_LOWER_Z)
            conv = s_tdata - CASE_OFFSET;
        else if (op_reg == OP_LOWER && s_tdata >= CHR_UPPER_A && s_tdata <= CHR_UPPER_Z)
            conv = s_tdata + CASE_OFFSET;
    end

    assign is_last = (({1'b0, seen_reg} + 9'd1) >= {1'b0, len_reg});

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        kind_next  = KIND_STRAY;
        last_next  = 1'b0;
        res_next   = '0;
        case (phase_reg)
            PH_OP:
            begin
                if (s_tdata <= OP_MAX)
                begin
                    op_next    = s_tdata[2:0];
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next     = PH_START;
                    emit           = 1'b1;
                    kind_next      = KIND_BAD_OP;
                    res_next.value = s_tdata;
                end
            end
            PH_LEN:
            begin
                len_next   = s_tdata;
                seen_next  = '0;
                // zero length skips straight to the end byte
                phase_next = (s_tdata == 8'd0) ? PH_END : PH_DATA;
                emit       = 1'b1;
                kind_next  = KIND_HEADER;
                res_next.operation  = op_reg;
                res_next.value      = s_tdata;
                res_next.size_class = size_of(s_tdata, small_reg, medium_reg);
            end
            PH_DATA:
            begin
                emit      = 1'b1;
                kind_next = KIND_PAYLOAD;
                last_next = is_last;
                res_next.operation = op_reg;
                res_next.value     = conv;
                res_next.position  = seen_reg;
                seen_next = seen_reg + 8'd1;
                if (is_last)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                phase_next = PH_START;
                emit       = 1'b1;
                res_next.operation  = op_reg;
                res_next.value      = len_reg;
                res_next.size_class = size_of(len_reg, small_reg, medium_reg);
                if (s_tdata == end_reg)
                begin
                    kind_next = KIND_ACCEPT;
                    res_next.dispatched = (op_reg == OP_UPPER || op_reg == OP_LOWER
                                           || op_reg == OP_UPPER_ALT);
                end
                else
                    kind_next = KIND_BAD_END;
            end
            default:
            begin
                phase_next = PH_START;
                if (s_tdata == start_reg)
                    phase_next = PH_OP;
                else
                begin
                    emit           = 1'b1;
                    kind_next      = KIND_STRAY;
                    res_next.value = s_tdata;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            op_reg        <= '0;
            len_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
            end
            if (s_tready)
                out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg  <= res_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_PAYLOAD))
        else $error("tlast on a beat that is not a payload byte");

    a_disp_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[21]) |-> (m_tuser == KIND_ACCEPT))
        else $error("dispatched flag on a beat that is not a frame accept");

    a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (seen_reg < len_reg))
        else $error("payload index ran past frame length");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_START && s_tdata == start_reg)
        |=> (!m_tvalid && phase_reg == PH_OP))
        else $error("start byte gave a result or missed the operation phase");
`endif

endmodule

`default_nettype wire
